// File: rtl/word_memory_alu_with_stack_assert.svh
// ---------------------------------------------------------------------------
// word_memory_alu_with_stack assertion macros
// Short forms for the concurrent assertions of the port checker.
// ---------------------------------------------------------------------------
`ifndef WORD_MEMORY_ALU_WITH_STACK_ASSERT_SVH
`define WORD_MEMORY_ALU_WITH_STACK_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define WMAS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define WMAS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/wmas_pkg.sv
// ---------------------------------------------------------------------------
// wmas_pkg
// Types and constants shared by the word memory ALU blocks.
// ---------------------------------------------------------------------------
package wmas_pkg;

   localparam int WORD_W     = 16;
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 2;

   typedef enum logic [1:0] {
      ACT_ALU    = 2'd0,
      ACT_PUSH   = 2'd1,
      ACT_READ   = 2'd2,
      ACT_SP_RST = 2'd3
   } action_type;

   localparam logic [2:0] OP_NOOP = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;

   typedef enum logic [1:0] {
      DSEL_MAP_A = 2'd0,
      DSEL_MAP_B = 2'd1,
      DSEL_ALU   = 2'd2
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_MAP_A,
      ST_WAIT_A,
      ST_MAP_B,
      ST_WAIT_B,
      ST_RD_A,
      ST_RD_B,
      ST_LATCH_Y,
      ST_READ_LATCH,
      ST_EXEC,
      ST_DIV_WAIT,
      ST_WRITE,
      ST_PUSH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        capture;
      logic        load_ia;
      logic        load_ib;
      logic        div_start;
      div_sel_type div_sel;
      logic        rd_sel_b;
      logic        latch_x;
      logic        latch_y;
      logic        latch_read;
      logic        exec;
      logic        load_quo;
      logic        alu_wr;
      logic        push;
      logic        sp_reset;
      logic        clr_wr;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       pow2;
      logic       clr_last;
      logic       div_busy;
      logic       div_go;
      logic       out_busy;
   } sts_type;

endpackage

// File: rtl/wmas_ram.sv
// ---------------------------------------------------------------------------
// wmas_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module wmas_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/wmas_div.sv
// ---------------------------------------------------------------------------
// wmas_div
// Restoring 16-bit unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module wmas_div
   import wmas_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] dividend,
   input  logic [WORD_W-1:0] divisor,
   output logic              busy,
   output logic [WORD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(WORD_W + 1);

   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic [WORD_W-1:0] rem_ff,  rem_in;
   logic [WORD_W-1:0] quo_ff,  quo_in;
   logic [WORD_W-1:0] dvs_ff,  dvs_in;
   logic [WORD_W:0]   shifted;
   logic [WORD_W:0]   diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[WORD_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in = CNT_W'(WORD_W);
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (!diff[WORD_W]) begin
            rem_in = diff[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

// File: rtl/wmas_dp.sv
// ---------------------------------------------------------------------------
// wmas_dp
// Datapath: item registers, word memory, ALU, divider, stack pointer and
// the result output register.
// ---------------------------------------------------------------------------
module wmas_dp
   import wmas_pkg::*;
#(
   parameter int MEM_WORDS = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [WORD_W-1:0]     rsp_tdata,
   output logic                  rsp_tuser
);

   localparam int                AW       = $clog2(MEM_WORDS);
   localparam logic [AW-1:0]     TOP_ADDR = AW'(MEM_WORDS - 1);
   localparam logic [WORD_W-1:0] MEM_MOD  = WORD_W'(MEM_WORDS);
   localparam logic              POW2     = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);
   // 2^32 / MEM_WORDS rounded up; the quotient it gives is exact for 16-bit
   // addresses.
   localparam logic [31:0]       MAP_RCP  =
      32'(((64'd1 << 32) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS));

   action_type        act_ff;
   logic [2:0]        op_ff;
   logic [WORD_W-1:0] addr_a_ff, addr_b_ff, value_ff;
   logic [AW-1:0]     ia_ff, ib_ff, sp_ff, sp_in, clr_ff;
   logic [WORD_W-1:0] x_ff, y_ff, r_ff, r_in, res_ff;
   logic              dz_ff;
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_data_ff;
   logic              rsp_dz_ff;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;
   logic [WORD_W-1:0] div_quo;
   logic              div_busy;
   logic [2*WORD_W-1:0] product;

   logic [WORD_W-1:0]   map_src, map_src_ff, map_q_ff, map_rem;
   logic [3*WORD_W-1:0] map_prod;
   logic [2*WORD_W-1:0] map_qm;

   // Memory port selection.
   always_comb begin
      ram_we    = cmd.clr_wr | cmd.push | cmd.alu_wr;
      ram_waddr = ia_ff;
      ram_wdata = r_ff;
      if (cmd.clr_wr) begin
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else if (cmd.push) begin
         ram_waddr = sp_ff;
         ram_wdata = value_ff;
      end
      ram_raddr = cmd.rd_sel_b ? ib_ff : ia_ff;
   end

   wmas_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MEM_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Address reduction for a memory that is not a power of two: the quotient
   // comes from a reciprocal multiplication and is registered, the remainder
   // from a multiply and subtract on that registered quotient.
   always_comb begin
      map_src  = (cmd.div_sel == DSEL_MAP_B) ? addr_b_ff : addr_a_ff;
      map_prod = {32'd0, map_src} * {16'd0, MAP_RCP};
      map_qm   = {16'd0, map_q_ff} * {16'd0, MEM_MOD};
      map_rem  = map_src_ff - map_qm[WORD_W-1:0];
   end

   wmas_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (x_ff),
      .divisor  (y_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // ALU; no-op, divide and unknown opcodes leave the word as it was here.
   always_comb begin
      product = x_ff * y_ff;
      unique case (op_ff)
         OP_ADD:  r_in = x_ff + y_ff;
         OP_SUB:  r_in = x_ff - y_ff;
         OP_MUL:  r_in = product[WORD_W-1:0];
         default: r_in = x_ff;
      endcase
   end

   always_comb begin
      sp_in = sp_ff;
      if (cmd.sp_reset) begin
         sp_in = TOP_ADDR;
      end else if (cmd.push) begin
         sp_in = (sp_ff == '0) ? TOP_ADDR : sp_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= TOP_ADDR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff <= sp_in;
         if (cmd.clr_wr) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff    <= action_type'(req_tuser);
         op_ff     <= req_tdata[2:0];
         addr_a_ff <= req_tdata[18:3];
         addr_b_ff <= req_tdata[34:19];
         value_ff  <= req_tdata[50:35];
         res_ff    <= '0;
         dz_ff     <= 1'b0;
      end else begin
         if (cmd.latch_read) begin
            res_ff <= ram_rdata;
         end else if (cmd.push) begin
            res_ff <= WORD_W'(sp_ff);
         end
         if (cmd.exec) begin
            dz_ff <= (op_ff == OP_DIV) && (y_ff == '0);
         end
      end
      if (cmd.div_sel != DSEL_ALU) begin
         map_src_ff <= map_src;
         map_q_ff   <= map_prod[3*WORD_W-1:2*WORD_W];
      end
      if (cmd.load_ia) begin
         ia_ff <= POW2 ? addr_a_ff[AW-1:0] : map_rem[AW-1:0];
      end
      if (cmd.load_ib) begin
         ib_ff <= POW2 ? addr_b_ff[AW-1:0] : map_rem[AW-1:0];
      end
      if (cmd.latch_x) begin
         x_ff <= ram_rdata;
      end
      if (cmd.latch_y) begin
         y_ff <= ram_rdata;
      end
      if (cmd.exec) begin
         r_ff <= r_in;
      end else if (cmd.load_quo) begin
         r_ff <= div_quo;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= res_ff;
         rsp_dz_ff   <= dz_ff;
      end
   end

   assign sts.action   = act_ff;
   assign sts.pow2     = POW2;
   assign sts.clr_last = (clr_ff == TOP_ADDR);
   assign sts.div_busy = div_busy;
   assign sts.div_go   = (op_ff == OP_DIV) && (y_ff != '0);
   assign sts.out_busy = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_dz_ff;

endmodule

// File: rtl/wmas_ctrl.sv
// ---------------------------------------------------------------------------
// wmas_ctrl
// Controller state machine sequencing one item at a time through the
// datapath.
// ---------------------------------------------------------------------------
module wmas_ctrl
   import wmas_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:      if (sts.clr_last) state_in = ST_IDLE;
         ST_IDLE:       if (req_tvalid) state_in = ST_DECODE;
         ST_DECODE: begin
            unique case (sts.action)
               ACT_ALU, ACT_READ: state_in = sts.pow2 ? ST_RD_A : ST_MAP_A;
               ACT_PUSH:          state_in = ST_PUSH;
               default:           state_in = ST_FINISH;
            endcase
         end
         ST_MAP_A:      state_in = ST_WAIT_A;
         ST_WAIT_A: begin
            if (!sts.div_busy) begin
               state_in = (sts.action == ACT_ALU) ? ST_MAP_B : ST_RD_A;
            end
         end
         ST_MAP_B:      state_in = ST_WAIT_B;
         ST_WAIT_B:     if (!sts.div_busy) state_in = ST_RD_A;
         ST_RD_A:       state_in = (sts.action == ACT_ALU) ? ST_RD_B : ST_READ_LATCH;
         ST_RD_B:       state_in = ST_LATCH_Y;
         ST_LATCH_Y:    state_in = ST_EXEC;
         ST_READ_LATCH: state_in = ST_FINISH;
         ST_EXEC:       state_in = sts.div_go ? ST_DIV_WAIT : ST_WRITE;
         ST_DIV_WAIT:   if (!sts.div_busy) state_in = ST_WRITE;
         ST_WRITE:      state_in = ST_FINISH;
         ST_PUSH:       state_in = ST_FINISH;
         ST_FINISH:     if (!sts.out_busy) state_in = ST_IDLE;
         default:       state_in = ST_CLEAR;
      endcase
   end

   // Commands.
   always_comb begin
      cmd         = '0;
      cmd.div_sel = DSEL_ALU;
      req_tready  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_wr = 1'b1;
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_DECODE: begin
            cmd.load_ia  = sts.pow2;
            cmd.load_ib  = sts.pow2;
            cmd.sp_reset = (sts.action == ACT_SP_RST);
         end
         ST_MAP_A:      cmd.div_sel = DSEL_MAP_A;
         ST_WAIT_A:     cmd.load_ia = !sts.div_busy;
         ST_MAP_B:      cmd.div_sel = DSEL_MAP_B;
         ST_WAIT_B:     cmd.load_ib = !sts.div_busy;
         ST_RD_A:       cmd.rd_sel_b = 1'b0;
         ST_RD_B: begin
            cmd.rd_sel_b = 1'b1;
            cmd.latch_x  = 1'b1;
         end
         ST_LATCH_Y:    cmd.latch_y = 1'b1;
         ST_READ_LATCH: cmd.latch_read = 1'b1;
         ST_EXEC: begin
            cmd.exec      = 1'b1;
            cmd.div_start = sts.div_go;
         end
         ST_DIV_WAIT:   cmd.load_quo = !sts.div_busy;
         ST_WRITE:      cmd.alu_wr = 1'b1;
         ST_PUSH:       cmd.push = 1'b1;
         ST_FINISH:     cmd.out_load = !sts.out_busy;
         default:       cmd.div_sel = DSEL_ALU;
      endcase
   end

endmodule

// File: rtl/word_memory_alu_with_stack.sv
// ---------------------------------------------------------------------------
// word_memory_alu_with_stack
// A word memory with an in-place ALU, a downward stack pointer and word
// reads, sequenced by a controller over a separate datapath.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Content
//   req_*     in         action in tuser; opcode, addr_a, addr_b, value in tdata
//   rsp_*     out        result_word in tdata; div_zero in tuser
//
// After reset the memory is cleared by a pass over all MEM_WORDS words,
// one word a cycle; req_tready stays low until that pass is over.
// Items are handled one at a time; a divide by a non-zero word also
// waits on the bit-serial divider. With a MEM_WORDS that is not a power
// of two, each address is reduced by a reciprocal multiplication
// followed by a multiply and subtract, one address for a read and two
// for an ALU item.
// A result held in the output register does not stop the next transfer
// in; only the next result waits for rsp_tready.
// ---------------------------------------------------------------------------
module word_memory_alu_with_stack
   import wmas_pkg::*;
#(
   parameter int MEM_WORDS = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] opcode, [18:3] addr_a, [34:19] addr_b, [50:35] value, rest zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] result_word
   output logic [WORD_W-1:0]     rsp_tdata,
   // [0] div_zero
   output logic                  rsp_tuser
);

   // The controller only issues commands; all data stays in the datapath.
   cmd_type cmd;
   sts_type sts;

   wmas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath owns the memory, the divider, the stack pointer and the
   // output register, so a finished result can wait there for its transfer.
   wmas_dp #(
      .MEM_WORDS (MEM_WORDS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: rtl/wmas_chk.sv
// ---------------------------------------------------------------------------
// wmas_chk
// Port checker for the word memory ALU block, bound to the top level.
// ---------------------------------------------------------------------------
`include "word_memory_alu_with_stack_assert.svh"

module wmas_chk
   import wmas_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [WORD_W-1:0]     rsp_tdata,
   input logic                  rsp_tuser
);

   // A stalled result holds.
   `WMAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // Only one item is in work at a time.
   `WMAS_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready, "input taken while an item is in work")

   // A failed divide reports a zero word.
   `WMAS_ASSERT_IMPL(a_dz_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "divide by zero with a non-zero result word")

   // The clearing pass follows reset with both channels quiet.
   `WMAS_ASSERT_IMPL(a_clear_pass, clock, reset, $fell(reset), !req_tready && !rsp_tvalid, "channel active straight after reset")

endmodule

bind word_memory_alu_with_stack wmas_chk u_chk (.*);
